// ----- hdl/cst_pkg.sv -----
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types and codes of the client session table.
// ----------------------------------------------------------------------------
package cst_pkg;

	localparam int unsigned TIMEOUT_W   = 16;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd5;

	typedef enum logic [1:0] {
		RT_DISCOVER  = 2'd0,
		RT_KEEPALIVE = 2'd1,
		RT_CHUNK     = 2'd2,
		RT_OTHER     = 2'd3
	} req_type_t;

	typedef enum logic [3:0] {
		ST_IAM       = 4'd0,
		ST_SERVED    = 4'd1,
		ST_FULL      = 4'd2,
		ST_DROPPED   = 4'd3,
		ST_REFRESHED = 4'd4,
		ST_UNKNOWN   = 4'd5,
		ST_SEND      = 4'd6,
		ST_DONE      = 4'd7,
		ST_IGNORED   = 4'd8
	} status_t;

	typedef struct packed {
		req_type_t   req_type;
		logic [31:0] client_addr;
		logic [15:0] src_port;
		logic [15:0] msg_length;
		logic [31:0] now_seconds;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] dest_addr;
		logic [15:0] dest_port;
		logic [3:0]  slot_index;
		logic        last_result;
	} result_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [15:0] port;
		logic [31:0] stamp;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

// ----- hdl/cst_ram.sv -----
// ----------------------------------------------------------------------------
// cst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cst_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/cst_seq.sv -----
// ----------------------------------------------------------------------------
// cst_seq
// Slot sequencer: walks the slot memory one entry at a time, keeps the
// valid bits, updates entries and drives the result register.
// ----------------------------------------------------------------------------
module cst_seq
	import cst_pkg::*;
#(
	parameter int unsigned NUM_SLOTS = 16,
	localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  req_t                 req,
	output logic                 out_valid,
	input  logic                 out_stall,
	output result_t              res,
	input  logic [TIMEOUT_W-1:0] idle_timeout,
	output logic                 mem_we,
	output logic [IW-1:0]        mem_waddr,
	output entry_t               mem_wdata,
	output logic                 mem_re,
	output logic [IW-1:0]        mem_raddr,
	input  entry_t               mem_rdata
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_READ  = 4'b0010,
		S_CHECK = 4'b0100,
		S_FINAL = 4'b1000
	} state_t;

	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

	state_t         state_q;
	logic [IW-1:0]  idx_q;
	req_type_t      type_q;
	logic [31:0]    addr_q;
	logic [15:0]    port_q;
	logic [31:0]    now_q;
	logic           drop_q;
	logic           hit_q;
	logic [IW-1:0]  hit_idx_q;
	logic [NUM_SLOTS-1:0] valid_q;
	result_t        out_q;
	logic           out_valid_q;

	logic           accept;
	logic           out_free;
	logic           slot_v;
	logic           live;
	logic           match;
	logic [31:0]    age;
	logic           free_found;
	logic [IW-1:0]  free_idx;
	result_t        send_res;
	result_t        final_res;
	logic           final_we;
	logic [IW-1:0]  final_widx;
	logic           final_set_valid;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign slot_v = valid_q[idx_q];
	assign age    = now_q - mem_rdata.stamp;
	assign live   = age < {16'd0, idle_timeout};
	assign match  = slot_v && (port_q != 16'd0) && (mem_rdata.addr == addr_q)
		&& (mem_rdata.port == port_q);

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
		end
	end

	always_comb begin
		send_res.status      = ST_SEND;
		send_res.dest_addr   = mem_rdata.addr;
		send_res.dest_port   = mem_rdata.port;
		send_res.slot_index  = 4'(idx_q);
		send_res.last_result = 1'b0;
	end

	always_comb begin
		final_res.status      = ST_IGNORED;
		final_res.dest_addr   = addr_q;
		final_res.dest_port   = port_q;
		final_res.slot_index  = 4'd0;
		final_res.last_result = 1'b1;
		final_we              = 1'b0;
		final_widx            = hit_idx_q;
		final_set_valid       = 1'b0;
		if (type_q == RT_CHUNK) begin
			final_res.status    = ST_DONE;
			final_res.dest_addr = 32'd0;
			final_res.dest_port = 16'd0;
		end else if (drop_q) begin
			final_res.status = ST_DROPPED;
		end else begin
			case (type_q)
				RT_DISCOVER: begin
					if (hit_q) begin
						final_res.status     = ST_SERVED;
						final_res.slot_index = 4'(hit_idx_q);
					end else if (free_found) begin
						final_res.status     = ST_IAM;
						final_res.slot_index = 4'(free_idx);
						final_we             = 1'b1;
						final_widx           = free_idx;
						final_set_valid      = 1'b1;
					end else begin
						final_res.status = ST_FULL;
					end
				end
				RT_KEEPALIVE: begin
					if (hit_q) begin
						final_res.status     = ST_REFRESHED;
						final_res.slot_index = 4'(hit_idx_q);
						final_we             = 1'b1;
					end else begin
						final_res.status = ST_UNKNOWN;
					end
				end
				default: begin
					final_res.status = ST_IGNORED;
				end
			endcase
		end
	end

	assign mem_re          = (state_q == S_READ);
	assign mem_raddr       = idx_q;
	assign mem_we          = (state_q == S_FINAL) && out_free && final_we;
	assign mem_waddr       = final_widx;
	assign mem_wdata.addr  = addr_q;
	assign mem_wdata.port  = port_q;
	assign mem_wdata.stamp = now_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			type_q <= req.req_type;
			addr_q <= req.client_addr;
			port_q <= req.src_port;
			now_q  <= req.now_seconds;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			drop_q      <= 1'b0;
			hit_q       <= 1'b0;
			hit_idx_q   <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q  <= '0;
						hit_q  <= 1'b0;
						drop_q <= (req.req_type != RT_CHUNK)
							&& ((req.client_addr == 32'd0) || (req.msg_length != 16'd0));
						if (req.req_type == RT_CHUNK) begin
							state_q <= S_READ;
						end else if ((req.client_addr == 32'd0)
							|| (req.msg_length != 16'd0) || (req.req_type == RT_OTHER)) begin
							state_q <= S_FINAL;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (type_q == RT_CHUNK) begin
						if (slot_v && live) begin
							if (out_free) begin
								out_q       <= send_res;
								out_valid_q <= 1'b1;
								if (idx_q == LAST_IDX) begin
									state_q <= S_FINAL;
								end else begin
									idx_q   <= idx_q + 1'b1;
									state_q <= S_READ;
								end
							end
						end else begin
							if (slot_v) begin
								valid_q[idx_q] <= 1'b0;
							end
							if (idx_q == LAST_IDX) begin
								state_q <= S_FINAL;
							end else begin
								idx_q   <= idx_q + 1'b1;
								state_q <= S_READ;
							end
						end
					end else if (match) begin
						hit_q     <= 1'b1;
						hit_idx_q <= idx_q;
						state_q   <= S_FINAL;
					end else if (idx_q == LAST_IDX) begin
						state_q <= S_FINAL;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_FINAL: begin
					if (out_free) begin
						out_q       <= final_res;
						out_valid_q <= 1'b1;
						if (final_set_valid) begin
							valid_q[final_widx] <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign res       = out_q;

endmodule

// ----- hdl/client_session_table.sv -----
// ----------------------------------------------------------------------------
// client_session_table
// Client slot table with idle timeout, kept in a synchronous slot memory.
// ----------------------------------------------------------------------------
// Requests enter on the in channel (in_valid, in_stall) and results leave on
// the out channel (out_valid, out_stall); an item moves when valid is high
// and stall is low. One request is worked on at a time.
// Dropped and ignored requests skip the slot walk and go straight to the
// final state, which writes their result and frees the input together once
// the result register is free. Discover, keepalive and data chunk requests
// walk the slot memory one slot at a time, each slot in a read state and
// then a compare state; a keepalive or discover that hits stops the walk at
// the matching slot. The read and the compare of a slot are not overlapped.
// A data chunk gives one send result per live slot and a final done result;
// every other request gives one result. last_result marks the final one.
// The result register holds while out_stall is high and the walk pauses on
// the next send until it is taken; a new request is taken once the final
// result is in the result register.
// The idle_timeout register is written on the cfg channel (always ready).
// Reset empties the table (valid bits clear at once, no clearing pass) and
// sets idle_timeout to 5 seconds.
// ----------------------------------------------------------------------------
module client_session_table
	import cst_pkg::*;
#(
	parameter int unsigned NUM_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [31:0] client_addr,
	input  logic [15:0] src_port,
	input  logic [15:0] msg_length,
	input  logic [31:0] now_seconds,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  status,
	output logic [31:0] dest_addr,
	output logic [15:0] dest_port,
	output logic [3:0]  slot_index,
	output logic        last_result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	logic [TIMEOUT_W-1:0] timeout_q;
	req_t                 req;
	result_t              res;
	logic                 mem_we;
	logic [IW-1:0]        mem_waddr;
	entry_t               mem_wdata;
	logic                 mem_re;
	logic [IW-1:0]        mem_raddr;
	logic [ENTRY_W-1:0]   mem_rdata_raw;
	entry_t               mem_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= cfg_data;
		end
	end

	assign req.req_type    = req_type_t'(req_type);
	assign req.client_addr = client_addr;
	assign req.src_port    = src_port;
	assign req.msg_length  = msg_length;
	assign req.now_seconds = now_seconds;

	cst_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata_raw)
	);

	assign mem_rdata = mem_rdata_raw;

	cst_seq #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req          (req),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.res          (res),
		.idle_timeout (timeout_q),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata)
	);

	assign status      = res.status;
	assign dest_addr   = res.dest_addr;
	assign dest_port   = res.dest_port;
	assign slot_index  = res.slot_index;
	assign last_result = res.last_result;

endmodule

// ----- hdl/cst_checker.sv -----
// ----------------------------------------------------------------------------
// cst_checker
// Port-level checks of the client session table, bound to the top level.
// ----------------------------------------------------------------------------
module cst_checker
	import cst_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [3:0]  status,
	input logic [31:0] dest_addr,
	input logic [15:0] dest_port,
	input logic [3:0]  slot_index,
	input logic        last_result
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)
			&& $stable(dest_addr) && $stable(dest_port) && $stable(slot_index)
			&& $stable(last_result))
		else $error("result changed while stalled");

	// one item at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item accepted while busy");

	// only send results are not final
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((status == ST_SEND) == !last_result))
		else $error("last_result does not match status");

	// done and failure results carry no slot
	a_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_DONE || status == ST_FULL || status == ST_DROPPED
			|| status == ST_UNKNOWN || status == ST_IGNORED) |-> slot_index == 4'd0)
		else $error("slot index on a slotless result");

endmodule

bind client_session_table cst_checker u_cst_checker (.*);

// ----- sim/session_table_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// session_table_checker
// Watches the request, result and cfg channels of the client session table,
// keeps its own copy of the slot table and idle timeout, works out the
// results of every accepted request and compares each accepted result with
// the oldest one still expected.
// ----------------------------------------------------------------------------
module session_table_checker
	import cst_pkg::*;
#(
	parameter int unsigned NUM_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [31:0] client_addr,
	input  logic [15:0] src_port,
	input  logic [15:0] msg_length,
	input  logic [31:0] now_seconds,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [3:0]  status,
	input  logic [31:0] dest_addr,
	input  logic [15:0] dest_port,
	input  logic [3:0]  slot_index,
	input  logic        last_result,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending
);

	result_t                 owed_results[$];
	logic                    slot_live[NUM_SLOTS];
	entry_t                  slot_entry[NUM_SLOTS];
	logic [TIMEOUT_W-1:0]    idle_secs;

	task automatic report(input string what);
		fail_count++;
		$display("%0t ns: result mismatch: %s", $time, what);
	endtask

	function automatic void owe(input status_t st, input logic [31:0] addr,
			input logic [15:0] port, input logic [3:0] idx, input logic last);
		result_t r;
		r.status      = st;
		r.dest_addr   = addr;
		r.dest_port   = port;
		r.slot_index  = idx;
		r.last_result = last;
		owed_results.push_back(r);
	endfunction

	function automatic int lookup_client(input logic [31:0] addr, input logic [15:0] port);
		int i;
		lookup_client = -1;
		if (port != 16'd0) begin
			for (i = NUM_SLOTS - 1; i >= 0; i--)
				if (slot_live[i] && slot_entry[i].addr == addr && slot_entry[i].port == port)
					lookup_client = i;
		end
	endfunction

	function automatic int first_free_slot();
		int i;
		first_free_slot = -1;
		for (i = NUM_SLOTS - 1; i >= 0; i--)
			if (!slot_live[i])
				first_free_slot = i;
	endfunction

	function automatic void serve_request(input req_type_t kind, input logic [31:0] addr,
			input logic [15:0] port, input logic [15:0] len, input logic [31:0] now);
		int          i;
		int          s;
		logic [31:0] age;
		if (kind == RT_CHUNK) begin
			for (i = 0; i < NUM_SLOTS; i++) begin
				if (slot_live[i]) begin
					age = now - slot_entry[i].stamp;
					if (age < {16'd0, idle_secs}) begin
						owe(ST_SEND, slot_entry[i].addr, slot_entry[i].port, i[3:0], 1'b0);
					end else begin
						slot_live[i]  = 1'b0;
						slot_entry[i] = '0;
					end
				end
			end
			owe(ST_DONE, 32'd0, 16'd0, 4'd0, 1'b1);
		end else if (addr == 32'd0 || len != 16'd0) begin
			owe(ST_DROPPED, addr, port, 4'd0, 1'b1);
		end else if (kind == RT_DISCOVER) begin
			s = lookup_client(addr, port);
			if (s >= 0) begin
				owe(ST_SERVED, addr, port, s[3:0], 1'b1);
			end else begin
				s = first_free_slot();
				if (s < 0) begin
					owe(ST_FULL, addr, port, 4'd0, 1'b1);
				end else begin
					slot_live[s]        = 1'b1;
					slot_entry[s].addr  = addr;
					slot_entry[s].port  = port;
					slot_entry[s].stamp = now;
					owe(ST_IAM, addr, port, s[3:0], 1'b1);
				end
			end
		end else if (kind == RT_KEEPALIVE) begin
			s = lookup_client(addr, port);
			if (s < 0) begin
				owe(ST_UNKNOWN, addr, port, 4'd0, 1'b1);
			end else begin
				slot_entry[s].stamp = now;
				owe(ST_REFRESHED, addr, port, s[3:0], 1'b1);
			end
		end else begin
			owe(ST_IGNORED, addr, port, 4'd0, 1'b1);
		end
	endfunction

	task automatic check_result();
		result_t want;
		if (owed_results.size() == 0) begin
			report($sformatf("result with none expected: status %0d addr %h port %h slot %0d",
				status, dest_addr, dest_port, slot_index));
		end else begin
			want = owed_results.pop_front();
			if (status != want.status)
				report($sformatf("status %0d, expected %0d", status, want.status));
			if (dest_addr != want.dest_addr)
				report($sformatf("dest_addr %h, expected %h", dest_addr, want.dest_addr));
			if (dest_port != want.dest_port)
				report($sformatf("dest_port %h, expected %h", dest_port, want.dest_port));
			if (slot_index != want.slot_index)
				report($sformatf("slot_index %0d, expected %0d", slot_index, want.slot_index));
			if (last_result != want.last_result)
				report($sformatf("last_result %b, expected %b", last_result, want.last_result));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		int i;
		if (!arst_n) begin
			owed_results.delete();
			idle_secs = TIMEOUT_RESET;
			for (i = 0; i < NUM_SLOTS; i++) begin
				slot_live[i]  = 1'b0;
				slot_entry[i] = '0;
			end
		end else begin
			if (out_valid && !out_stall)
				check_result();
			if (cfg_valid && cfg_ready)
				idle_secs = cfg_data;
			if (in_valid && !in_stall)
				serve_request(req_type_t'(req_type), client_addr, src_port, msg_length,
					now_seconds);
		end
		pending = owed_results.size();
	end

endmodule

// ----- sim/client_session_table_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// client_session_table_tb
// Drives requests and idle timeout writes into the client session table and
// lets the session table checker predict and compare every result. A short
// directed run covers drops, ignored types, port zero, a full table, address
// and time wrap, zero and maximum timeout and a clock going back; random
// traffic from a small client pool follows under three idling patterns,
// with one long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module client_session_table_tb;
	import cst_pkg::*;

	localparam int CYCLE_LIMIT      = 500000;
	localparam int DRAIN_CYCLES     = 50;
	localparam int HOLD_CYCLES      = 300;
	localparam int POOL_SIZE        = 20;
	localparam int RANDOM_PER_PHASE = 44;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  req_type;
	logic [31:0] client_addr;
	logic [15:0] src_port;
	logic [15:0] msg_length;
	logic [31:0] now_seconds;
	logic        out_valid;
	logic        out_stall;
	logic [3:0]  status;
	logic [31:0] dest_addr;
	logic [15:0] dest_port;
	logic [3:0]  slot_index;
	logic        last_result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	int          fail_count;
	int          pending;
	int          cycles;
	int          send_idle_pct;
	int          recv_idle_pct;
	logic        hold_toggle;
	logic [31:0] clock_now;
	logic [31:0] pool_addr[POOL_SIZE];
	logic [15:0] pool_port[POOL_SIZE];

	client_session_table dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.client_addr (client_addr),
		.src_port    (src_port),
		.msg_length  (msg_length),
		.now_seconds (now_seconds),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.dest_addr   (dest_addr),
		.dest_port   (dest_port),
		.slot_index  (slot_index),
		.last_result (last_result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	session_table_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.client_addr (client_addr),
		.src_port    (src_port),
		.msg_length  (msg_length),
		.now_seconds (now_seconds),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.dest_addr   (dest_addr),
		.dest_port   (dest_port),
		.slot_index  (slot_index),
		.last_result (last_result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("** client_session_table: FAILED **");
			$finish;
		end
	end

	// receiver: random stall, or a long hold-off when the toggle flips
	initial begin : receiver
		logic seen;
		int   n;
		seen = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_toggle !== seen) begin
				seen = hold_toggle;
				for (n = 0; n < HOLD_CYCLES; n++) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic offer(input req_type_t kind, input logic [31:0] addr,
			input logic [15:0] port, input logic [15:0] len, input logic [31:0] now);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= kind;
		client_addr <= addr;
		src_port    <= port;
		msg_length  <= len;
		now_seconds <= now;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [15:0] secs);
		cfg_valid <= 1'b1;
		cfg_data  <= secs;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic offer_random();
		int          pick;
		int          who;
		int          step;
		req_type_t   kind;
		logic [31:0] addr;
		pick = $urandom_range(99);
		who  = $urandom_range(POOL_SIZE - 1);
		step = $urandom_range(99);
		if (step < 3)
			clock_now = clock_now - $urandom_range(1, 8);
		else if (step < 6)
			clock_now = clock_now + $urandom_range(50, 100000);
		else
			clock_now = clock_now + $urandom_range(0, 2);
		kind = req_type_t'($urandom_range(2));
		if (kind == RT_CHUNK)
			kind = RT_OTHER;
		addr = $urandom;
		if (addr == 32'd0)
			addr = 32'd1;
		if (pick < 30) begin
			offer(RT_DISCOVER, pool_addr[who], pool_port[who], 16'd0, clock_now);
		end else if (pick < 55) begin
			offer(RT_KEEPALIVE, pool_addr[who], pool_port[who], 16'd0, clock_now);
		end else if (pick < 75) begin
			offer(RT_CHUNK, $urandom, 16'($urandom), 16'($urandom), clock_now);
		end else begin
			case ($urandom_range(3))
				0: offer(kind, 32'd0, 16'($urandom), 16'($urandom), $urandom);
				1: offer(kind, addr, 16'($urandom), 16'($urandom_range(1, 65535)), $urandom);
				2: offer(RT_OTHER, pool_addr[who], pool_port[who], 16'd0, $urandom);
				default: offer(kind, addr, 16'($urandom), 16'd0, clock_now);
			endcase
		end
	endtask

	initial begin : stimulus
		int phase;
		int n;
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		req_type      <= RT_DISCOVER;
		client_addr   <= '0;
		src_port      <= '0;
		msg_length    <= '0;
		now_seconds   <= '0;
		cfg_valid     <= 1'b0;
		cfg_data      <= '0;
		hold_toggle   <= 1'b0;
		send_idle_pct = 17;
		recv_idle_pct = 66;
		clock_now     = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_timeout(16'd3);
		offer(RT_DISCOVER, 32'hFFFF_FFFF, 16'hFFFF, 16'd0, 32'hFFFF_FFFE);
		offer(RT_DISCOVER, 32'hFFFF_FFFF, 16'hFFFF, 16'd0, 32'hFFFF_FFFE);
		offer(RT_DISCOVER, 32'd0, 16'h1234, 16'd0, 32'd7);
		offer(RT_KEEPALIVE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'd7);
		offer(RT_OTHER, 32'h0000_0001, 16'h0001, 16'd0, 32'd7);
		offer(RT_KEEPALIVE, 32'hFFFF_FFFF, 16'hFFFF, 16'd0, 32'hFFFF_FFFF);
		offer(RT_KEEPALIVE, 32'h8000_0000, 16'h0001, 16'd0, 32'hFFFF_FFFF);
		// port zero never matches: two fresh slots, then unknown
		offer(RT_DISCOVER, 32'h0A00_0001, 16'd0, 16'd0, 32'hFFFF_FFFF);
		offer(RT_DISCOVER, 32'h0A00_0001, 16'd0, 16'd0, 32'hFFFF_FFFF);
		offer(RT_KEEPALIVE, 32'h0A00_0001, 16'd0, 16'd0, 32'hFFFF_FFFF);
		offer(RT_CHUNK, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'd0);
		for (n = 0; n < 13; n++)
			offer(RT_DISCOVER, 32'h0B00_0000 + n, n[15:0] + 16'd1, 16'd0, 32'd1);
		offer(RT_DISCOVER, 32'h0C00_0000, 16'h0100, 16'd0, 32'd1);
		wait_drained();
		write_timeout(16'd0);
		offer(RT_CHUNK, 32'd0, 16'd0, 16'd0, 32'd1);
		wait_drained();
		write_timeout(16'hFFFF);
		offer(RT_DISCOVER, 32'h5555_5555, 16'hAAAA, 16'd0, 32'd1000);
		// time going back makes the client look very old
		offer(RT_CHUNK, 32'h5555_5555, 16'hAAAA, 16'd0, 32'd999);

		for (n = 0; n < POOL_SIZE; n++) begin
			pool_addr[n] = $urandom;
			if (pool_addr[n] == 32'd0)
				pool_addr[n] = 32'd1;
			pool_port[n] = (n == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
		end

		for (phase = 0; phase < 3; phase++) begin
			wait_drained();
			case (phase)
				0: begin
					write_timeout(16'($urandom_range(2, 6)));
					send_idle_pct = 17;
					recv_idle_pct = 66;
				end
				1: begin
					write_timeout(16'd1);
					send_idle_pct = 66;
					recv_idle_pct = 17;
				end
				default: begin
					write_timeout(16'hFFFF);
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			clock_now = $urandom;
			for (n = 0; n < RANDOM_PER_PHASE; n++) begin
				if (phase == 2 && n == 30)
					hold_toggle <= ~hold_toggle;
				offer_random();
			end
		end
		wait_drained();

		if (fail_count == 0)
			$display("** client_session_table: PASSED **");
		else
			$display("** client_session_table: FAILED **");
		$finish;
	end

endmodule
